// ===== sv/ugsh_pkg.sv =====
// ----------------------------------------------------------------------------
// ugsh_pkg: shared types and constants
// Types, constants and register map for uplink group/sequence hopping.
// ----------------------------------------------------------------------------
`default_nettype none

package ugsh_pkg;

    localparam int SUBCARRIERS_PER_RB = 12;
    localparam int GOLD_ADVANCE       = 1600;
    localparam int GOLD_LEN           = 31;
    localparam int ADV_STEPS          = GOLD_ADVANCE - GOLD_LEN;
    localparam int MIN_SEQ_LEN        = 6 * SUBCARRIERS_PER_RB;

    localparam int ID_W   = 9;
    localparam int SLOT_W = 5;
    localparam int NUM_W  = 5;
    localparam int CNT_W  = 11;
    localparam int LEN_W  = 11;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [GOLD_LEN-1:0] X1_ADVANCED = 31'h54D21B24;

    // floor(x/30) = (x * RECIP_30) >> RECIP_SHIFT, exact for x < 512
    localparam logic [10:0] RECIP_30    = 11'd1093;
    localparam int          RECIP_SHIFT = 15;

    localparam logic [1:0] ID_SEL_PUCCH = 2'd1;
    localparam logic [1:0] ID_SEL_PUSCH = 2'd2;

    typedef enum logic [2:0] {
        REG_CELL_ID      = 3'd0,
        REG_PUCCH_VID    = 3'd1,
        REG_PUSCH_VID    = 3'd2,
        REG_ID_SELECT    = 3'd3,
        REG_DELTA_SHIFT  = 3'd4,
        REG_GROUP_HOP_EN = 3'd5,
        REG_SEQ_HOP_EN   = 3'd6,
        REG_SEQ_LEN_SC   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]  cell_id;
        logic [ID_W-1:0]  pucch_vid;
        logic [ID_W-1:0]  pusch_vid;
        logic [1:0]       id_select;
        logic [4:0]       delta_shift;
        logic             group_hop_en;
        logic             seq_hop_en;
        logic [LEN_W-1:0] seq_len_sc;
    } cfg_t;

    typedef struct packed {
        logic setup_q;
        logic setup_r;
        logic load;
        logic seq_mode;
        logic adv2;
        logic step;
        logic gen;
        logic reduce;
        logic emit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/ugsh_regs.sv =====
// ----------------------------------------------------------------------------
// ugsh_regs: configuration register file
// APB-style register bank; writes complete in the access cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ugsh_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ugsh_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ugsh_pkg::DATA_W-1:0]  pwdata,
    output logic      [ugsh_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output ugsh_pkg::cfg_t                    cfg
);

    ugsh_pkg::cfg_t     cfg_reg;
    ugsh_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = ugsh_pkg::reg_idx_t'(paddr[ugsh_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                ugsh_pkg::REG_CELL_ID:      cfg_reg.cell_id      <= pwdata[8:0];
                ugsh_pkg::REG_PUCCH_VID:    cfg_reg.pucch_vid    <= pwdata[8:0];
                ugsh_pkg::REG_PUSCH_VID:    cfg_reg.pusch_vid    <= pwdata[8:0];
                ugsh_pkg::REG_ID_SELECT:    cfg_reg.id_select    <= pwdata[1:0];
                ugsh_pkg::REG_DELTA_SHIFT:  cfg_reg.delta_shift  <= pwdata[4:0];
                ugsh_pkg::REG_GROUP_HOP_EN: cfg_reg.group_hop_en <= pwdata[0];
                ugsh_pkg::REG_SEQ_HOP_EN:   cfg_reg.seq_hop_en   <= pwdata[0];
                ugsh_pkg::REG_SEQ_LEN_SC:   cfg_reg.seq_len_sc   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            ugsh_pkg::REG_CELL_ID:      prdata[8:0]  = cfg_reg.cell_id;
            ugsh_pkg::REG_PUCCH_VID:    prdata[8:0]  = cfg_reg.pucch_vid;
            ugsh_pkg::REG_PUSCH_VID:    prdata[8:0]  = cfg_reg.pusch_vid;
            ugsh_pkg::REG_ID_SELECT:    prdata[1:0]  = cfg_reg.id_select;
            ugsh_pkg::REG_DELTA_SHIFT:  prdata[4:0]  = cfg_reg.delta_shift;
            ugsh_pkg::REG_GROUP_HOP_EN: prdata[0]    = cfg_reg.group_hop_en;
            ugsh_pkg::REG_SEQ_HOP_EN:   prdata[0]    = cfg_reg.seq_hop_en;
            ugsh_pkg::REG_SEQ_LEN_SC:   prdata[10:0] = cfg_reg.seq_len_sc;
            default:                    prdata       = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ugsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ugsh_ctrl: sequencing controller
// Walks setup, then (for hopping) Gold generator advance, skip and bit capture, then reduce and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module ugsh_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ugsh_pkg::SLOT_W-1:0]  slot,
    input  wire ugsh_pkg::cfg_t               cfg,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output ugsh_pkg::dp_cmd_t                 cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP_Q,
        ST_SETUP_R,
        ST_LOAD,
        ST_ADV,
        ST_SKIP,
        ST_GEN,
        ST_REDUCE,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [ugsh_pkg::SLOT_W-1:0]   slot_reg;
    logic                          pat_mode_reg;
    logic                          seq_mode_reg;
    logic                          out_valid_reg;
    logic [ugsh_pkg::CNT_W-1:0]    cnt_reg;
    logic [ugsh_pkg::CNT_W-1:0]    skip_len;
    logic [ugsh_pkg::CNT_W-1:0]    gen_len;
    logic                          accept;
    logic                          emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign emit      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign skip_len  = pat_mode_reg ? ugsh_pkg::CNT_W'({slot_reg, 3'b000})
                                    : ugsh_pkg::CNT_W'(slot_reg);
    assign gen_len   = pat_mode_reg ? ugsh_pkg::CNT_W'(8) : ugsh_pkg::CNT_W'(1);

    always_comb
    begin
        cmd          = '0;
        cmd.seq_mode = seq_mode_reg;
        cmd.emit     = emit;
        case (state_reg)
            ST_SETUP_Q: cmd.setup_q = 1'b1;
            ST_SETUP_R: cmd.setup_r = 1'b1;
            ST_LOAD:    cmd.load    = 1'b1;
            ST_ADV:     cmd.adv2    = 1'b1;
            ST_SKIP:    cmd.step    = 1'b1;
            ST_GEN:     cmd.gen     = 1'b1;
            ST_REDUCE:  cmd.reduce  = 1'b1;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            pat_mode_reg  <= 1'b0;
            seq_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg     <= slot;
                        pat_mode_reg <= cfg.group_hop_en;
                        seq_mode_reg <= !cfg.group_hop_en && cfg.seq_hop_en &&
                                        (cfg.seq_len_sc >=
                                         ugsh_pkg::LEN_W'(ugsh_pkg::MIN_SEQ_LEN));
                        state_reg    <= ST_SETUP_Q;
                    end
                end
                ST_SETUP_Q:
                begin
                    state_reg <= ST_SETUP_R;
                end
                ST_SETUP_R:
                begin
                    state_reg <= (pat_mode_reg || seq_mode_reg) ? ST_LOAD : ST_REDUCE;
                end
                ST_LOAD:
                begin
                    cnt_reg   <= ugsh_pkg::CNT_W'(ugsh_pkg::ADV_STEPS - 1);
                    state_reg <= ST_ADV;
                end
                ST_ADV:
                begin
                    if (cnt_reg == '0)
                    begin
                        if (skip_len == '0)
                        begin
                            cnt_reg   <= gen_len - 1'b1;
                            state_reg <= ST_GEN;
                        end
                        else
                        begin
                            cnt_reg   <= skip_len - 1'b1;
                            state_reg <= ST_SKIP;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_SKIP:
                begin
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= gen_len - 1'b1;
                        state_reg <= ST_GEN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_GEN:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_REDUCE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_REDUCE:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/ugsh_dp.sv =====
// ----------------------------------------------------------------------------
// ugsh_dp: hopping datapath
// Identity split by 30, Gold sequence registers, pattern capture and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ugsh_dp (
    input  wire logic                        clk,
    input  wire ugsh_pkg::cfg_t              cfg,
    input  wire ugsh_pkg::dp_cmd_t           cmd,
    output logic [ugsh_pkg::NUM_W-1:0]       group_u,
    output logic                             seq_v,
    output logic [ugsh_pkg::NUM_W-1:0]       hop_pattern,
    output logic [ugsh_pkg::NUM_W-1:0]       group_shift
);

    logic [ugsh_pkg::ID_W-1:0]       id_sel;
    logic [ugsh_pkg::ID_W-1:0]       id_reg;
    logic [4:0]                      q_reg;
    logic [4:0]                      shift_reg;
    logic [ugsh_pkg::GOLD_LEN-1:0]   x1_reg;
    logic [ugsh_pkg::GOLD_LEN-1:0]   x2_reg;
    logic [7:0]                      acc_reg;
    logic                            v_reg;
    logic [4:0]                      pat_reg;
    logic [4:0]                      u_out_reg;
    logic                            v_out_reg;
    logic [4:0]                      pat_out_reg;
    logic [4:0]                      shift_out_reg;

    logic [19:0] id_prod;
    logic [9:0]  id_rem;
    logic [5:0]  off_sum;
    logic [5:0]  off_mod;
    logic [9:0]  seq_init;
    logic [18:0] acc_prod;
    logic [3:0]  acc_q;
    logic [8:0]  acc_rem;
    logic [5:0]  u_sum;
    logic [5:0]  u_mod;
    logic        b1;
    logic        b2;
    logic        c_bit;

    always_comb
    begin
        case (cfg.id_select)
            ugsh_pkg::ID_SEL_PUCCH: id_sel = cfg.pucch_vid;
            ugsh_pkg::ID_SEL_PUSCH: id_sel = cfg.pusch_vid;
            default:                id_sel = cfg.cell_id;
        endcase
    end

    assign id_prod = 20'(id_sel) * 20'(ugsh_pkg::RECIP_30);
    assign id_rem  = {1'b0, id_reg} - (10'({q_reg, 5'b00000}) - 10'({q_reg, 1'b0}));

    assign off_sum  = {1'b0, shift_reg} + {1'b0, cfg.delta_shift};
    assign off_mod  = (off_sum >= 6'd60) ? off_sum - 6'd60 :
                      (off_sum >= 6'd30) ? off_sum - 6'd30 : off_sum;
    assign seq_init = {q_reg, off_mod[4:0]};

    assign acc_prod = 19'(acc_reg) * 19'(ugsh_pkg::RECIP_30);
    assign acc_q    = acc_prod[18:ugsh_pkg::RECIP_SHIFT];
    assign acc_rem  = {1'b0, acc_reg} - (9'({acc_q, 5'b00000}) - 9'({acc_q, 1'b0}));

    assign u_sum = {1'b0, pat_reg} + {1'b0, shift_reg};
    assign u_mod = (u_sum >= 6'd30) ? u_sum - 6'd30 : u_sum;

    assign b1    = x1_reg[0] ^ x1_reg[3];
    assign b2    = x2_reg[0] ^ x2_reg[1] ^ x2_reg[2] ^ x2_reg[3];
    assign c_bit = b1 ^ b2;

    always_ff @(posedge clk)
    begin
        if (cmd.setup_q)
        begin
            id_reg  <= id_sel;
            q_reg   <= id_prod[ugsh_pkg::RECIP_SHIFT +: 5];
            acc_reg <= '0;
            v_reg   <= 1'b0;
        end
        if (cmd.setup_r)
        begin
            shift_reg <= id_rem[4:0];
        end
        if (cmd.load)
        begin
            x1_reg <= ugsh_pkg::X1_ADVANCED;
            x2_reg <= cmd.seq_mode ? ugsh_pkg::GOLD_LEN'(seq_init)
                                   : ugsh_pkg::GOLD_LEN'(q_reg);
        end
        if (cmd.adv2)
        begin
            x2_reg <= {b2, x2_reg[ugsh_pkg::GOLD_LEN-1:1]};
        end
        if (cmd.step || cmd.gen)
        begin
            x1_reg <= {b1, x1_reg[ugsh_pkg::GOLD_LEN-1:1]};
            x2_reg <= {b2, x2_reg[ugsh_pkg::GOLD_LEN-1:1]};
        end
        if (cmd.gen)
        begin
            if (cmd.seq_mode)
            begin
                v_reg <= c_bit;
            end
            else
            begin
                acc_reg <= {c_bit, acc_reg[7:1]};
            end
        end
        if (cmd.reduce)
        begin
            pat_reg <= acc_rem[4:0];
        end
        if (cmd.emit)
        begin
            u_out_reg     <= u_mod[4:0];
            v_out_reg     <= v_reg;
            pat_out_reg   <= pat_reg;
            shift_out_reg <= shift_reg;
        end
    end

    assign group_u     = u_out_reg;
    assign seq_v       = v_out_reg;
    assign hop_pattern = pat_out_reg;
    assign group_shift = shift_out_reg;

endmodule

`default_nettype wire

// ===== sv/uplink_group_sequence_hopping.sv =====
// ----------------------------------------------------------------------------
// uplink_group_sequence_hopping: uplink RS group and sequence hopping
// Per slot: group number u, hopping pattern, group shift and sequence
// number v from a bit-serial length-31 Gold sequence generator.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         in_valid/in_ready    slot
//  output    out        out_valid/out_ready  group_u, seq_v, hop_pattern,
//                                            group_shift
//  config    in         APB psel/penable     paddr, pwdata, prdata
//
//  One slot at a time. Group hopping: setup, load, advance x2, skip 8*slot
//  bits, capture 8 bits, reduce, emit; sequence hopping skips slot bits and
//  captures one; neither: setup, reduce, emit. The Gold generator runs one
//  bit per cycle and pre-advances x2 by ADV_STEPS shifts.
//  A new slot is accepted while the previous result waits in the output
//  register; a stalled output holds the next result in the emit state.
//  Reset clears configuration and control; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module uplink_group_sequence_hopping (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ugsh_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ugsh_pkg::DATA_W-1:0]  pwdata,
    output logic      [ugsh_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ugsh_pkg::SLOT_W-1:0]  slot,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [ugsh_pkg::NUM_W-1:0]   group_u,
    output logic                              seq_v,
    output logic      [ugsh_pkg::NUM_W-1:0]   hop_pattern,
    output logic      [ugsh_pkg::NUM_W-1:0]   group_shift
);

    ugsh_pkg::cfg_t    cfg;
    ugsh_pkg::dp_cmd_t cmd;

    ugsh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ugsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .slot      (slot),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ugsh_dp u_dp (
        .clk         (clk),
        .cfg         (cfg),
        .cmd         (cmd),
        .group_u     (group_u),
        .seq_v       (seq_v),
        .hop_pattern (hop_pattern),
        .group_shift (group_shift)
    );

endmodule

`default_nettype wire
